// ===== sv/cale_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cale_pkg: shared types and constants of the link endpoint
// Cell flag bits, event bits, fault codes, mode codes and the classified word
// handed from the front part to the back part.
// ----------------------------------------------------------------------------
package cale_pkg;

  localparam int unsigned Channels  = 8;
  localparam int unsigned ChW       = 3;
  localparam logic [4:0]  CreditMax = 5'd31;
  localparam int unsigned QDepth    = 2;

  typedef enum logic [2:0] {
    MODE_TX      = 3'd0,
    MODE_RX      = 3'd1,
    MODE_QUEUE   = 3'd2,
    MODE_RELEASE = 3'd3,
    MODE_SET     = 3'd4
  } mode_e;

  localparam int unsigned FlReliable    = 0;
  localparam int unsigned FlUrgent      = 1;
  localparam int unsigned FlAckValid    = 2;
  localparam int unsigned FlCreditValid = 3;

  localparam logic [4:0] EvRx     = 5'h01;
  localparam logic [4:0] EvDup    = 5'h02;
  localparam logic [4:0] EvAcked  = 5'h04;
  localparam logic [4:0] EvFault  = 5'h08;
  localparam logic [4:0] EvAccept = 5'h01;

  localparam logic [2:0] FaultNone   = 3'd0;
  localparam logic [2:0] FaultBad    = 3'd1;
  localparam logic [2:0] FaultAck    = 3'd2;
  localparam logic [2:0] FaultSeq    = 3'd3;
  localparam logic [2:0] FaultCredit = 3'd4;

  localparam logic [4:0] TypeFault = 5'd31;

  localparam logic [23:0] PrioReset = 24'hFAC688;

  localparam logic [0:0] CfgInitCredit = 1'b0;
  localparam logic [0:0] CfgPriority   = 1'b1;

  // classified word: valid modes only
  typedef struct packed {
    mode_e       mode;
    logic [2:0]  channel;
    logic [4:0]  cell_type;
    logic [15:0] cell_flags;
    logic [15:0] sequence_req;
    logic [2:0]  status_channel;
    logic [4:0]  status_credit;
    logic [15:0] acknowledgement;
    logic        cell_ok;
    logic [7:0]  amount;
    logic [15:0] payload_handle;
  } word_t;

  typedef struct packed {
    logic [4:0]  status_word;
    logic [2:0]  out_channel;
    logic [4:0]  out_type;
    logic [15:0] out_flags;
    logic [15:0] out_sequence;
    logic [2:0]  out_status_channel;
    logic [4:0]  out_status_credit;
    logic [15:0] out_ack;
    logic [47:0] out_payload;
    logic [2:0]  fault_code;
    logic [2:0]  acked_channel;
    logic [15:0] acked_sequence;
  } result_t;

  function automatic logic [4:0] sat_credit(input logic [8:0] v);
    return (v > {4'd0, CreditMax}) ? CreditMax : v[4:0];
  endfunction

endpackage

// ===== sv/credit_ack_link_endpoint.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// credit_ack_link_endpoint: eight-channel credit/ack link endpoint
// A pushed word passes through the word queue and then the result queue.
// Throughput: one word per cycle while the result queue has room.
// Reset clears the channel state but for the queued-cell payloads; local credits
// come up at zero, priority order at 0..7. Unknown modes are dropped with no result.
// ----------------------------------------------------------------------------
module credit_ack_link_endpoint import cale_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  mode_i,
  input  logic [2:0]  channel_i,
  input  logic [4:0]  cell_type_i,
  input  logic [15:0] cell_flags_i,
  input  logic [15:0] sequence_req_i,
  input  logic [2:0]  status_channel_i,
  input  logic [4:0]  status_credit_i,
  input  logic [15:0] acknowledgement_i,
  input  logic        cell_ok_i,
  input  logic [7:0]  amount_i,
  input  logic [15:0] payload_handle_i,
  output logic        empty,
  input  logic        pop,
  output logic [4:0]  status_word_o,
  output logic [2:0]  out_channel_o,
  output logic [4:0]  out_type_o,
  output logic [15:0] out_flags_o,
  output logic [15:0] out_sequence_o,
  output logic [2:0]  out_status_channel_o,
  output logic [4:0]  out_status_credit_o,
  output logic [15:0] out_ack_o,
  output logic [47:0] out_payload_o,
  output logic [2:0]  fault_code_o,
  output logic [2:0]  acked_channel_o,
  output logic [15:0] acked_sequence_o
);

  logic    wvalid, wtake;
  word_t   word;
  result_t res;

  assign cfg_ready_o = 1'b1;

  cale_front u_front (
    .clk_i, .rst_ni,
    .push_i(push), .full_o(full),
    .mode_i, .channel_i, .cell_type_i, .cell_flags_i, .sequence_req_i,
    .status_channel_i, .status_credit_i, .acknowledgement_i, .cell_ok_i,
    .amount_i, .payload_handle_i,
    .wvalid_o(wvalid), .word_o(word), .wtake_i(wtake)
  );

  cale_back u_back (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_valid_i), .cfg_idx_i(cfg_index_i), .cfg_data_i,
    .wvalid_i(wvalid), .word_i(word), .wtake_o(wtake),
    .empty_o(empty), .pop_i(pop), .res_o(res)
  );

  assign status_word_o        = res.status_word;
  assign out_channel_o        = res.out_channel;
  assign out_type_o           = res.out_type;
  assign out_flags_o          = res.out_flags;
  assign out_sequence_o       = res.out_sequence;
  assign out_status_channel_o = res.out_status_channel;
  assign out_status_credit_o  = res.out_status_credit;
  assign out_ack_o            = res.out_ack;
  assign out_payload_o        = res.out_payload;
  assign fault_code_o         = res.fault_code;
  assign acked_channel_o      = res.acked_channel;
  assign acked_sequence_o     = res.acked_sequence;

  // transmit results carry the credit-valid flag and status word 0; status credit <= CreditMax
  a_tx_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && res.status_word == 5'd0 && res.out_flags[FlCreditValid]) |->
    (res.out_status_credit <= CreditMax))
    else $error("bad status credit");

  // an ack report only comes with the acked event bit
  a_acked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && res.acked_sequence != 16'd0) |-> res.status_word[2])
    else $error("ack report without event");

  // a fault cell is urgent and on channel 0
  a_fault_cell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && res.out_type == TypeFault && res.out_flags[FlCreditValid] &&
     res.fault_code != FaultNone) |-> (res.out_channel == 3'd0))
    else $error("fault cell on wrong channel");

endmodule

// ===== sv/cale_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cale_front: input classifier and word queue
// Drops unknown modes and buffers classified words for the back part.
// ----------------------------------------------------------------------------
module cale_front import cale_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  output logic        full_o,
  input  logic [2:0]  mode_i,
  input  logic [2:0]  channel_i,
  input  logic [4:0]  cell_type_i,
  input  logic [15:0] cell_flags_i,
  input  logic [15:0] sequence_req_i,
  input  logic [2:0]  status_channel_i,
  input  logic [4:0]  status_credit_i,
  input  logic [15:0] acknowledgement_i,
  input  logic        cell_ok_i,
  input  logic [7:0]  amount_i,
  input  logic [15:0] payload_handle_i,
  output logic        wvalid_o,
  output word_t       word_o,
  input  logic        wtake_i
);

  word_t      mem_q [QDepth];
  logic [0:0] wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       acc, keep, take;
  word_t      w;

  assign full_o   = (cnt_q == 2'(QDepth));
  assign acc      = push_i && !full_o;
  assign keep     = acc && (mode_i <= MODE_SET);
  assign wvalid_o = (cnt_q != 2'd0);
  assign take     = wtake_i && wvalid_o;
  assign word_o   = mem_q[rp_q];

  // classify into a packed word
  always_comb begin
    w.mode            = mode_e'(mode_i);
    w.channel         = channel_i;
    w.cell_type       = cell_type_i;
    w.cell_flags      = cell_flags_i;
    w.sequence_req    = sequence_req_i;
    w.status_channel  = status_channel_i;
    w.status_credit   = status_credit_i;
    w.acknowledgement = acknowledgement_i;
    w.cell_ok         = cell_ok_i;
    w.amount          = amount_i;
    w.payload_handle  = payload_handle_i;
  end

  always_ff @(posedge clk_i) begin
    if (keep) mem_q[wp_q] <= w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (keep) wp_q <= wp_q + 1'b1;
      if (take) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + 2'(keep) - 2'(take);
    end
  end

endmodule

// ===== sv/cale_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cale_back: link state and cell execution
// Executes one word per cycle, while the output queue has room, against the
// channel state and writes the result into a two-entry output queue.
// ----------------------------------------------------------------------------
module cale_back import cale_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i,
  input  logic        wvalid_i,
  input  word_t       word_i,
  output logic        wtake_o,
  output logic        empty_o,
  input  logic        pop_i,
  output result_t     res_o
);

  logic [4:0]  local_credit_q [Channels];
  logic [4:0]  peer_credit_q  [Channels];
  logic [15:0] tx_next_seq_q  [Channels];
  logic [4:0]  qc_type_q      [Channels];
  logic [15:0] qc_flags_q     [Channels];
  logic [15:0] qc_handle_q    [Channels];
  logic [15:0] rx_last_seq_q  [Channels];
  logic [15:0] rx_exp_seq_q   [Channels];
  logic [15:0] tx_acked_seq_q [Channels];
  logic [7:0]  queued_mask_q, ack_pend_q, rx_seen_q, tx_acked_mask_q;
  logic        inf_valid_q;
  logic [2:0]  inf_chan_q;
  logic [4:0]  inf_type_q;
  logic [15:0] inf_flags_q, inf_seq_q, inf_handle_q;
  logic [2:0]  cursor_q;
  logic [2:0]  flt_code_q, flt_chan_q;
  logic [15:0] flt_exp_q, flt_obs_q;
  logic [23:0] prio_q;

  // output queue
  result_t    oq_q [QDepth];
  logic [0:0] owp_q, orp_q;
  logic [1:0] ocnt_q;
  logic       otake, go;

  assign empty_o = (ocnt_q == 2'd0);
  assign res_o   = oq_q[orp_q];
  assign otake   = pop_i && !empty_o;
  assign wtake_o = (ocnt_q != 2'(QDepth));
  assign go      = wvalid_i && wtake_o;

  // transmit selection: priority scan
  logic       sel_ok;
  logic [2:0] sel_ch;
  always_comb begin
    logic [2:0] c;
    sel_ok = 1'b0;
    sel_ch = '0;
    for (int i = 0; i < Channels; i++) begin
      c = prio_q[3*i +: 3];
      if (!sel_ok && queued_mask_q[c] &&
          !(qc_flags_q[c][FlReliable] && peer_credit_q[c] == 5'd0)) begin
        sel_ok = 1'b1;
        sel_ch = c;
      end
    end
  end

  // status channel: round-robin scan of pending acks
  logic       has_ack;
  logic [2:0] sch_rr;
  always_comb begin
    logic [2:0] c;
    has_ack = 1'b0;
    sch_rr  = cursor_q;
    for (int k = 0; k < Channels; k++) begin
      c = cursor_q + 3'(k);
      if (!has_ack && ack_pend_q[c]) begin
        has_ack = 1'b1;
        sch_rr  = c;
      end
    end
  end

  // execution
  result_t    r;
  logic       lat;
  logic [2:0] lcode, lchan;
  logic [15:0] lexp, lobs;
  logic       do_sel, rx_ack_ok, rx_acc_rel, rx_rt, q_ok;
  logic [2:0] ch, sch;
  logic [7:0] bit_m;
  logic [15:0] fl;

  always_comb begin
    r          = '0;
    lat        = 1'b0;
    lcode      = '0;
    lchan      = '0;
    lexp       = '0;
    lobs       = '0;
    do_sel     = 1'b0;
    rx_ack_ok  = 1'b0;
    rx_acc_rel = 1'b0;
    rx_rt      = 1'b0;
    q_ok       = 1'b0;
    fl         = '0;
    ch         = word_i.channel;
    sch        = word_i.status_channel;
    bit_m      = 8'(1) << ch;
    unique case (word_i.mode)
      MODE_TX: begin
        if (flt_code_q != FaultNone) begin
          r.out_type    = TypeFault;
          fl            = 16'(1) << FlUrgent;
          r.out_payload = {flt_obs_q, flt_exp_q, 5'd0, flt_chan_q, 5'd0, flt_code_q};
        end else if (inf_valid_q) begin
          r.out_channel  = inf_chan_q;
          r.out_type     = inf_type_q;
          fl             = inf_flags_q;
          r.out_sequence = inf_seq_q;
          r.out_payload  = {32'd0, inf_handle_q};
        end else if (sel_ok) begin
          do_sel         = 1'b1;
          r.out_channel  = sel_ch;
          r.out_type     = qc_type_q[sel_ch];
          fl             = qc_flags_q[sel_ch];
          r.out_sequence = tx_next_seq_q[sel_ch];
          r.out_payload  = {32'd0, qc_handle_q[sel_ch]};
        end
        fl[FlCreditValid]    = 1'b1;
        fl[FlAckValid]       = has_ack;
        r.out_flags          = fl;
        r.out_status_channel = sch_rr;
        r.out_status_credit  = local_credit_q[sch_rr];
        r.out_ack            = has_ack ? rx_last_seq_q[sch_rr] : 16'd0;
        r.fault_code         = flt_code_q;
      end
      MODE_RX: begin
        if (!word_i.cell_ok) begin
          lat   = 1'b1;
          lcode = FaultBad;
          r.status_word = EvFault;
          r.fault_code  = (flt_code_q != FaultNone) ? flt_code_q : FaultBad;
        end else begin
          if (word_i.cell_flags[FlAckValid]) begin
            if (inf_valid_q && sch == inf_chan_q && word_i.acknowledgement == inf_seq_q) begin
              rx_ack_ok        = 1'b1;
              r.status_word    = r.status_word | EvAcked;
              r.acked_channel  = sch;
              r.acked_sequence = word_i.acknowledgement;
            end else if (!(tx_acked_mask_q[sch] &&
                           tx_acked_seq_q[sch] == word_i.acknowledgement)) begin
              lat   = 1'b1;
              lcode = FaultAck;
              lchan = sch;
              lexp  = inf_valid_q ? inf_seq_q : 16'd0;
              lobs  = word_i.acknowledgement;
              r.status_word = r.status_word | EvFault;
            end
          end
          // sequence checks are skipped once a fault is latched or the ack check raised one
          if (flt_code_q == FaultNone && !lat && word_i.cell_type != 5'd0) begin
            if (word_i.cell_flags[FlReliable]) begin
              if (rx_seen_q[ch] && word_i.sequence_req == rx_last_seq_q[ch]) begin
                r.status_word = r.status_word | EvDup;
              end else if (word_i.sequence_req != rx_exp_seq_q[ch]) begin
                lat   = 1'b1;
                lcode = FaultSeq;
                lchan = ch;
                lexp  = rx_exp_seq_q[ch];
                lobs  = word_i.sequence_req;
                r.status_word = r.status_word | EvFault;
              end else if (local_credit_q[ch] == 5'd0) begin
                lat   = 1'b1;
                lcode = FaultCredit;
                lchan = ch;
                lexp  = 16'd1;
                r.status_word = r.status_word | EvFault;
              end else begin
                rx_acc_rel    = 1'b1;
                r.status_word = r.status_word | EvRx;
              end
            end else begin
              rx_rt         = 1'b1;
              r.status_word = r.status_word | EvRx;
            end
            if ((r.status_word & (EvRx | EvDup)) != 5'd0) begin
              r.out_channel  = ch;
              r.out_type     = word_i.cell_type;
              r.out_sequence = word_i.sequence_req;
            end
          end
          if (lat) r.fault_code = (flt_code_q != FaultNone) ? flt_code_q : lcode;
        end
      end
      MODE_QUEUE: begin
        q_ok = (flt_code_q == FaultNone) && !queued_mask_q[ch];
        r.status_word = q_ok ? EvAccept : 5'd0;
      end
      MODE_RELEASE: r.status_word = (word_i.amount != 8'd0) ? EvAccept : 5'd0;
      MODE_SET:     r.status_word = EvAccept;
      default: ;
    endcase
  end

  logic [4:0] cfg_credit;
  assign cfg_credit = sat_credit({4'd0, cfg_data_i[4:0]});

  // state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Channels; i++) begin
        local_credit_q[i] <= '0;
        peer_credit_q[i]  <= '0;
        tx_next_seq_q[i]  <= '0;
        rx_last_seq_q[i]  <= '0;
        rx_exp_seq_q[i]   <= '0;
        tx_acked_seq_q[i] <= '0;
      end
      queued_mask_q   <= '0;
      ack_pend_q      <= '0;
      rx_seen_q       <= '0;
      tx_acked_mask_q <= '0;
      inf_valid_q     <= 1'b0;
      cursor_q        <= '0;
      flt_code_q      <= FaultNone;
      flt_chan_q      <= '0;
      flt_exp_q       <= '0;
      flt_obs_q       <= '0;
      prio_q          <= PrioReset;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgInitCredit) begin
          for (int i = 0; i < Channels; i++) local_credit_q[i] <= cfg_credit;
        end else begin
          prio_q <= cfg_data_i;
        end
      end
      if (go) begin
        if (lat && flt_code_q == FaultNone) begin
          flt_code_q <= lcode;
          flt_chan_q <= lchan;
          flt_exp_q  <= lexp;
          flt_obs_q  <= lobs;
        end
        unique case (word_i.mode)
          MODE_TX: begin
            cursor_q <= sch_rr + 3'd1;
            if (has_ack) ack_pend_q[sch_rr] <= 1'b0;
            if (do_sel) begin
              queued_mask_q[sel_ch] <= 1'b0;
              tx_next_seq_q[sel_ch] <= tx_next_seq_q[sel_ch] + 16'd1;
              if (qc_flags_q[sel_ch][FlReliable]) begin
                peer_credit_q[sel_ch] <= peer_credit_q[sel_ch] - 5'd1;
                inf_valid_q <= 1'b1;
              end
            end
          end
          MODE_RX: begin
            if (word_i.cell_ok) begin
              if (word_i.cell_flags[FlCreditValid])
                peer_credit_q[sch] <= sat_credit({4'd0, word_i.status_credit});
              if (rx_ack_ok) begin
                inf_valid_q          <= 1'b0;
                tx_acked_seq_q[sch]  <= word_i.acknowledgement;
                tx_acked_mask_q[sch] <= 1'b1;
              end
              if ((r.status_word & EvDup) != 5'd0) ack_pend_q <= ack_pend_q | bit_m;
              if (rx_acc_rel) begin
                local_credit_q[ch] <= local_credit_q[ch] - 5'd1;
                rx_seen_q[ch]      <= 1'b1;
                rx_last_seq_q[ch]  <= word_i.sequence_req;
                rx_exp_seq_q[ch]   <= word_i.sequence_req + 16'd1;
                ack_pend_q         <= ack_pend_q | bit_m;
              end
            end
          end
          MODE_QUEUE: if (q_ok) queued_mask_q[ch] <= 1'b1;
          MODE_RELEASE: begin
            if (word_i.amount != 8'd0)
              local_credit_q[ch] <= sat_credit(9'(local_credit_q[ch]) + 9'(word_i.amount));
          end
          MODE_SET: local_credit_q[ch] <= sat_credit({1'b0, word_i.amount});
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (go && word_i.mode == MODE_QUEUE && q_ok) begin
      qc_type_q[ch]   <= word_i.cell_type;
      qc_flags_q[ch]  <= word_i.cell_flags &
                         ~((16'(1) << FlAckValid) | (16'(1) << FlCreditValid));
      qc_handle_q[ch] <= word_i.payload_handle;
    end
    if (go && word_i.mode == MODE_TX && flt_code_q == FaultNone && !inf_valid_q &&
        do_sel && qc_flags_q[sel_ch][FlReliable]) begin
      inf_chan_q   <= sel_ch;
      inf_type_q   <= qc_type_q[sel_ch];
      inf_flags_q  <= qc_flags_q[sel_ch];
      inf_seq_q    <= tx_next_seq_q[sel_ch];
      inf_handle_q <= qc_handle_q[sel_ch];
    end
    if (go) oq_q[owp_q] <= r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owp_q  <= '0;
      orp_q  <= '0;
      ocnt_q <= '0;
    end else begin
      if (go)    owp_q <= owp_q + 1'b1;
      if (otake) orp_q <= orp_q + 1'b1;
      ocnt_q <= ocnt_q + 2'(go) - 2'(otake);
    end
  end

endmodule
